// ===== hdl/wavhp_pkg.sv =====
// wavhp_pkg: shared constants and result type of the wav header parser
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  // chunk and file tags, little-endian as assembled from the byte stream
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOT_WAV = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_UNSUPP  = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  localparam int RESULT_BITS = 122;
  localparam int TDATA_BITS  = 128;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  channels;
    logic [31:0] rate_hz;
    logic [15:0] block_align;
    logic [4:0]  sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } wavhp_result_t;

endpackage

`default_nettype wire

// ===== hdl/wav_header_parser_top.sv =====
// wav_header_parser_top: stream wrapper around the wav header parser core
// each byte is held in the input register; its result is registered when it steps the core
// throughput: one file byte per cycle, set by the combinational parse step in wavhp_core;
// the input stalls only while a finished result waits for the sink
// at most one result per file; bytes after it are dropped until the last byte
// rst (synchronous, active high) empties both registers and arms the parser for a new file
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  wire logic        s_axis_tlast,   // last_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [2:0], channels [4:3], rate_hz [36:5], block_align [52:37],
  // sample_bits [57:53], data_offset [89:58], data_size [121:90], zero [127:122]
  output logic [127:0]     m_axis_tdata
);
  import wavhp_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic                  out_valid;
  logic [TDATA_BITS-1:0] out_data;

  logic          step;
  logic          emit;
  wavhp_result_t result;

  // the held byte moves on when the result slot is free or being drained
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  wavhp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // pack fields lowest first
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data <= {(TDATA_BITS - RESULT_BITS)'(0), result.data_size, result.data_offset,
                   result.sample_bits, result.block_align, result.rate_hz,
                   result.channels, result.status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

// ===== hdl/wavhp_core.sv =====
// wavhp_core: byte-wise riff/wave chunk walker with fmt validation
`timescale 1ns / 1ps
`default_nettype none

module wavhp_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last_byte,
  output logic                         emit,
  output wavhp_pkg::wavhp_result_t     result
);
  import wavhp_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_SIZE   = 3'd2;
  localparam logic [2:0] PH_FMT    = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  // control state
  logic [2:0]  phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [4:0]  field_index, field_index_next;
  logic        seen_fmt, seen_fmt_next;
  logic        seen_data, seen_data_next;
  logic        finished, finished_next;

  // payload state
  logic [31:0] assembly_word, assembly_word_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [32:0] skip_count, skip_count_next;
  logic [31:0] fmt_rate, fmt_rate_next;
  logic [15:0] fmt_align, fmt_align_next;
  logic [1:0]  fmt_channels, fmt_channels_next;
  logic [4:0]  fmt_bits, fmt_bits_next;
  logic        fmt_bad, fmt_bad_next;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] data_size, data_size_next;

  logic        rearm;
  logic [2:0]  status;

  logic [31:0] word_shift;
  logic [15:0] half;
  logic [32:0] pad;

  assign word_shift = {data_byte, assembly_word[31:8]};
  assign half       = word_shift[31:16];
  assign pad        = {32'd0, word_shift[0]};

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    field_index_next   = field_index;
    seen_fmt_next      = seen_fmt;
    seen_data_next     = seen_data;
    finished_next      = finished;
    assembly_word_next = assembly_word;
    chunk_tag_next     = chunk_tag;
    skip_count_next    = skip_count;
    fmt_rate_next      = fmt_rate;
    fmt_align_next     = fmt_align;
    fmt_channels_next  = fmt_channels;
    fmt_bits_next      = fmt_bits;
    fmt_bad_next       = fmt_bad;
    data_offset_next   = data_offset;
    data_size_next     = data_size;
    emit               = 1'b0;
    status             = ST_OK;
    rearm              = 1'b0;

    if (finished) begin
      rearm = last_byte;
    end else begin
      byte_position_next = byte_position + 32'd1;
      case (phase)
        PH_HEADER: begin
          assembly_word_next = word_shift;
          if (field_index == 5'd3 && word_shift != TAG_RIFF) begin
            emit   = 1'b1;
            status = ST_NOT_WAV;
          end else if (field_index == 5'd11) begin
            if (word_shift != TAG_WAVE) begin
              emit   = 1'b1;
              status = ST_NOT_WAV;
            end else begin
              phase_next       = PH_ID;
              field_index_next = 5'd0;
            end
          end else begin
            field_index_next = field_index + 5'd1;
          end
        end
        PH_ID: begin
          chunk_tag_next = {data_byte, chunk_tag[31:8]};
          if (field_index >= 5'd3) begin
            phase_next       = PH_SIZE;
            field_index_next = 5'd0;
          end else begin
            field_index_next = field_index + 5'd1;
          end
        end
        PH_SIZE: begin
          assembly_word_next = word_shift;
          if (field_index < 5'd3) begin
            field_index_next = field_index + 5'd1;
          end else if (chunk_tag == TAG_FMT) begin
            if (word_shift < 32'd16) begin
              emit   = 1'b1;
              status = ST_BAD_HDR;
            end else begin
              skip_count_next   = {1'b0, word_shift - 32'd16} + pad;
              fmt_rate_next     = 32'd0;
              fmt_align_next    = 16'd0;
              fmt_channels_next = 2'd0;
              fmt_bits_next     = 5'd0;
              fmt_bad_next      = 1'b0;
              phase_next        = PH_FMT;
              field_index_next  = 5'd0;
            end
          end else begin
            if (chunk_tag == TAG_DATA) begin
              data_offset_next = byte_position_next;
              data_size_next   = word_shift;
              seen_data_next   = 1'b1;
            end
            if (chunk_tag == TAG_DATA && seen_fmt) begin
              emit   = 1'b1;
              status = ST_OK;
            end else begin
              // skip the body and its pad byte
              skip_count_next  = {1'b0, word_shift} + pad;
              phase_next       = (skip_count_next != 33'd0) ? PH_SKIP : PH_ID;
              field_index_next = 5'd0;
            end
          end
        end
        PH_FMT: begin
          assembly_word_next = word_shift;
          case (field_index)
            5'd1: begin
              if (half != 16'd1) fmt_bad_next = 1'b1;
            end
            5'd3: begin
              if (half == 16'd0 || half > 16'd2) fmt_bad_next = 1'b1;
              fmt_channels_next = half[1:0];
            end
            5'd7: begin
              if (word_shift == 32'd0) fmt_bad_next = 1'b1;
              fmt_rate_next = word_shift;
            end
            5'd13: begin
              fmt_align_next = half;
            end
            5'd15: begin
              if (half != 16'd8 && half != 16'd16) fmt_bad_next = 1'b1;
              fmt_bits_next = half[4:0];
            end
            default: begin
            end
          endcase
          if (field_index != 5'd15) begin
            field_index_next = field_index + 5'd1;
          end else if (fmt_bad_next) begin
            emit   = 1'b1;
            status = ST_UNSUPP;
          end else begin
            seen_fmt_next = 1'b1;
            if (seen_data) begin
              emit   = 1'b1;
              status = ST_OK;
            end else begin
              phase_next       = (skip_count != 33'd0) ? PH_SKIP : PH_ID;
              field_index_next = 5'd0;
            end
          end
        end
        default: begin
          if (skip_count != 33'd0) skip_count_next = skip_count - 33'd1;
          if (skip_count_next == 33'd0) begin
            phase_next       = PH_ID;
            field_index_next = 5'd0;
          end
        end
      endcase

      // end of file before a result: report by where the parse stands
      if (!emit && last_byte) begin
        emit = 1'b1;
        if (phase_next == PH_HEADER) status = ST_NOT_WAV;
        else if (phase_next == PH_FMT) status = ST_BAD_HDR;
        else status = ST_MISSING;
      end

      if (emit) finished_next = 1'b1;
      rearm = last_byte;
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.channels    = fmt_channels_next;
      result.rate_hz     = fmt_rate_next;
      result.block_align = fmt_align_next;
      result.sample_bits = fmt_bits_next;
      result.data_offset = data_offset_next;
      result.data_size   = data_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && rearm)) begin
      phase         <= PH_HEADER;
      byte_position <= 32'd0;
      field_index   <= 5'd0;
      seen_fmt      <= 1'b0;
      seen_data     <= 1'b0;
      finished      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      field_index   <= field_index_next;
      seen_fmt      <= seen_fmt_next;
      seen_data     <= seen_data_next;
      finished      <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      assembly_word <= assembly_word_next;
      chunk_tag     <= chunk_tag_next;
      skip_count    <= skip_count_next;
      fmt_rate      <= fmt_rate_next;
      fmt_align     <= fmt_align_next;
      fmt_channels  <= fmt_channels_next;
      fmt_bits      <= fmt_bits_next;
      fmt_bad       <= fmt_bad_next;
      data_offset   <= data_offset_next;
      data_size     <= data_size_next;
    end
  end

endmodule

`default_nettype wire
